>>> hdl/per_process_anomaly_scorer_macros.svh
// assertion macros of the anomaly scorer, used by the sequencer ppas_ctrl
`ifndef PER_PROCESS_ANOMALY_SCORER_MACROS_SVH
`define PER_PROCESS_ANOMALY_SCORER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PPAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PPAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ppas_pkg.sv
// types, codes and weight function of the anomaly scorer
`timescale 1ns / 1ps
package ppas_pkg;

  localparam int unsigned SLOTS  = 64;
  localparam int unsigned SLOT_W = 6;

  localparam logic [1:0] CMD_SCORE = 2'd0;
  localparam logic [1:0] CMD_CLONE = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [2:0] KIND_FAULT   = 3'd0;
  localparam logic [2:0] KIND_ACCESS  = 3'd1;
  localparam logic [2:0] KIND_NETWORK = 3'd2;
  localparam logic [2:0] KIND_CRYPTO  = 3'd3;
  localparam logic [2:0] KIND_CLONE   = 3'd4;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_WINDOW    = 3'd2;
  localparam logic [2:0] REG_BUDGET    = 3'd3;
  localparam logic [2:0] REG_COOLDOWN  = 3'd4;

  localparam logic [1:0] MODE_TRAP       = 2'd2;
  localparam logic [1:0] MODE_QUARANTINE = 2'd3;

  localparam logic [15:0] W_EXEC    = 16'd50;
  localparam logic [15:0] W_WRITE   = 16'd30;
  localparam logic [15:0] W_ACCESS  = 16'd10;
  localparam logic [15:0] W_NETWORK = 16'd10;
  localparam logic [15:0] W_CRYPTO  = 16'd80;

  localparam logic [15:0] SCORE_MAX = 16'hFFFF;
  localparam logic [7:0]  CLONE_MAX = 8'hFF;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_CALC  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_e;

  typedef struct packed {
    logic        pending;
    logic [7:0]  clone_total;
    logic [31:0] clone_stamp;
    logic [31:0] score_stamp;
    logic [15:0] score;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic rd_en;
    logic calc_en;
    logic wb_en;
  } ctrl_cmd_t;

  function automatic logic [15:0] weight_of(input logic [2:0] kind, input logic [1:0] flags,
                                            input logic [15:0] thr);
    logic [15:0] w;
    w = '0;
    case (kind)
      KIND_FAULT:   w = thr;
      KIND_ACCESS:  w = flags[0] ? W_EXEC : (flags[1] ? W_WRITE : W_ACCESS);
      KIND_NETWORK: w = W_NETWORK;
      KIND_CRYPTO:  w = W_CRYPTO;
      default:      w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> hdl/ppas_ctrl.sv
// sequencing state machine of the anomaly scorer
`timescale 1ns / 1ps
`include "per_process_anomaly_scorer_macros.svh"
module ppas_ctrl import ppas_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  assign busy_o = (state_q == ST_READ) || (state_q == ST_CALC);

  always_comb begin
    cmd_o.capture = start_i && !busy_o;
    cmd_o.rd_en   = (state_q == ST_READ);
    cmd_o.calc_en = (state_q == ST_CALC);
    cmd_o.wb_en   = (state_q == ST_WRITE);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  state_d = start_i ? ST_READ : ST_IDLE;
      ST_READ:  state_d = ST_CALC;
      ST_CALC:  state_d = ST_WRITE;
      ST_WRITE: state_d = start_i ? ST_READ : ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PPAS_ASSERT_NXT(a_accept_reads, cmd_o.capture, cmd_o.rd_en, "accepted transaction not read")
  `PPAS_ASSERT_NXT(a_read_calcs, cmd_o.rd_en, cmd_o.calc_en, "read not followed by calc")
  `PPAS_ASSERT_NXT(a_calc_writes, cmd_o.calc_en, cmd_o.wb_en, "calc not followed by write")
  `PPAS_ASSERT_IMP(a_one_phase, 1'b1, $onehot0({cmd_o.rd_en, cmd_o.calc_en, cmd_o.wb_en}),
                   "overlapping phases")

endmodule

>>> hdl/ppas_dpath.sv
// slot table, configuration registers and scoring datapath
`timescale 1ns / 1ps
module ppas_dpath import ppas_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic [1:0]        cmd_in_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [2:0]        kind_i,
  input  logic [1:0]        flags_i,
  input  logic              is_sandbox_i,
  input  logic [31:0]       now_tick_i,
  output logic              done_o,
  output logic              pending_o,
  output logic [15:0]       score_o,
  output logic [7:0]        clone_count_o,
  output logic              raised_o
);

  logic [1:0]  mode_q;
  logic [15:0] thr_q;
  logic [31:0] window_q;
  logic [7:0]  budget_q;
  logic [31:0] cooldown_q;

  logic [1:0]        cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [2:0]        kind_q;
  logic [1:0]        flags_q;
  logic              sandbox_q;
  logic [31:0]       now_q;

  entry_t           mem [SLOTS];
  entry_t           rdata_q;
  logic             rd_valid_q;
  logic [SLOTS-1:0] valid_q;
  entry_t           ent;
  entry_t           wdata;

  logic        active_q, stale_q, cool_q, budget_ok_q;
  logic [15:0] weight_q;

  logic        done_q, pending_q, raised_q;
  logic [15:0] score_q;
  logic [7:0]  clone_q;

  logic [15:0] base;
  logic [16:0] sum;
  logic [15:0] sat;
  logic        hit;
  logic        pend_out;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      thr_q      <= 16'd100;
      window_q   <= 32'd1000;
      budget_q   <= 8'd3;
      cooldown_q <= 32'd1000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:      mode_q     <= cfg_wdata_i[1:0];
        REG_THRESHOLD: thr_q      <= cfg_wdata_i[15:0];
        REG_WINDOW:    window_q   <= cfg_wdata_i;
        REG_BUDGET:    budget_q   <= cfg_wdata_i[7:0];
        REG_COOLDOWN:  cooldown_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q     <= cmd_in_i;
      slot_q    <= slot_i;
      kind_q    <= kind_i;
      flags_q   <= flags_i;
      sandbox_q <= is_sandbox_i;
      now_q     <= now_tick_i;
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb_en) begin
      mem[slot_q] <= wdata;
    end
  end

  // entry valid bits, a mode write empties the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[slot_q];
      end
      if (cfg_we_i && cfg_index_i == REG_MODE) begin
        valid_q <= '0;
      end else if (cmd_i.wb_en) begin
        valid_q[slot_q] <= 1'b1;
      end
    end
  end

  assign ent = rd_valid_q ? rdata_q : '0;

  // compare stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_en) begin
      active_q    <= (mode_q == MODE_TRAP || mode_q == MODE_QUARANTINE) && !sandbox_q &&
                     (kind_q != KIND_CLONE);
      stale_q     <= (ent.score != '0) && ((now_q - ent.score_stamp) > window_q);
      cool_q      <= (ent.clone_total != '0) && ((now_q - ent.clone_stamp) < cooldown_q);
      budget_ok_q <= ent.clone_total < budget_q;
      weight_q    <= weight_of(kind_q, flags_q, thr_q);
    end
  end

  // update stage
  always_comb begin
    base     = stale_q ? '0 : ent.score;
    sum      = {1'b0, base} + {1'b0, weight_q};
    sat      = sum[16] ? SCORE_MAX : sum[15:0];
    hit      = 1'b0;
    wdata    = ent;
    pend_out = ent.pending;
    case (cmd_q)
      CMD_SCORE: begin
        if (active_q) begin
          hit               = (sat >= thr_q) && budget_ok_q && !cool_q;
          wdata.score_stamp = now_q;
          wdata.score       = hit ? '0 : sat;
          wdata.pending     = hit ? 1'b1 : ent.pending;
        end
        pend_out = wdata.pending;
      end
      CMD_CLONE: begin
        wdata.clone_stamp = now_q;
        wdata.clone_total = (ent.clone_total == CLONE_MAX) ? CLONE_MAX :
                            ent.clone_total + 8'd1;
        wdata.pending     = 1'b0;
        pend_out          = 1'b0;
      end
      CMD_QUERY: begin
        wdata.pending = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.wb_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb_en) begin
      pending_q <= pend_out;
      score_q   <= wdata.score;
      clone_q   <= wdata.clone_total;
      raised_q  <= hit;
    end
  end

  assign done_o        = done_q;
  assign pending_o     = pending_q;
  assign score_o       = score_q;
  assign clone_count_o = clone_q;
  assign raised_o      = raised_q;

endmodule

>>> hdl/per_process_anomaly_scorer.sv
// top level of the per-process anomaly scorer
`timescale 1ns / 1ps
// Usage:
//   A transaction is taken at a rising edge with start_i high and busy_o low,
//   carrying cmd, slot, kind, flags, is_sandbox and now_tick. Each transaction
//   gives one result on pending_o, score_o, clone_count_o and raised_o, shown
//   for exactly one cycle while done_o is high; the receiver cannot stall it.
//   The slot table is read, compared and written back in three steps (memory
//   read, tick compares, saturating add and write-back); done_o is registered
//   from the write-back step. busy_o is high in the read and compare steps, so
//   the next transaction may be accepted in the write-back cycle.
//   Configuration: cfg_we_i writes register cfg_index_i (0 mode, 1 threshold,
//   2 window, 3 clone budget, 4 clone cooldown) from cfg_wdata_i; the user must
//   write only while no transaction is in flight; the block itself does not
//   enforce it. A mode write empties the table. Reset: asynchronous rst_ni
//   clears the sequencer, the entry valid bits and the configuration registers
//   to their defaults; the table reads as zero at once, with no clearing pass.
module per_process_anomaly_scorer import ppas_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        cmd_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [2:0]        kind_i,
  input  logic [1:0]        flags_i,
  input  logic              is_sandbox_i,
  input  logic [31:0]       now_tick_i,
  output logic              done_o,
  output logic              pending_o,
  output logic [15:0]       score_o,
  output logic [7:0]        clone_count_o,
  output logic              raised_o
);

  ctrl_cmd_t ctrl_cmd;

  ppas_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (ctrl_cmd)
  );

  ppas_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_in_i      (cmd_i),
    .slot_i        (slot_i),
    .kind_i        (kind_i),
    .flags_i       (flags_i),
    .is_sandbox_i  (is_sandbox_i),
    .now_tick_i    (now_tick_i),
    .done_o        (done_o),
    .pending_o     (pending_o),
    .score_o       (score_o),
    .clone_count_o (clone_count_o),
    .raised_o      (raised_o)
  );

endmodule

>>> sim/per_process_anomaly_scorer_tb.sv
// self-checking testbench of the anomaly scorer: directed and random transactions vs a table mirror
`timescale 1ns / 1ps
module per_process_anomaly_scorer_tb;
  import ppas_pkg::*;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_AUDIT = 2'd1;
  localparam logic [1:0] CMD_SPARE  = 2'd3;
  localparam logic [2:0] KIND_OTHER   = 3'd5;
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic              pending;
    logic [15:0]       score;
    logic [7:0]        clones;
    logic              raised;
  } slot_report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_index_i = '0;
  logic [31:0]       cfg_wdata_i = '0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [1:0]        cmd_i = '0;
  logic [SLOT_W-1:0] slot_i = '0;
  logic [2:0]        kind_i = '0;
  logic [1:0]        flags_i = '0;
  logic              is_sandbox_i = 1'b0;
  logic [31:0]       now_tick_i = '0;
  logic              done_o;
  logic              pending_o;
  logic [15:0]       score_o;
  logic [7:0]        clone_count_o;
  logic              raised_o;

  // mirror of the configuration and of the slot table
  logic [1:0]  cur_mode = MODE_OFF;
  logic [15:0] cur_threshold = 16'd100;
  logic [31:0] cur_window = 32'd1000;
  logic [7:0]  cur_budget = 8'd3;
  logic [31:0] cur_cooldown = 32'd1000;

  logic [15:0] tbl_score      [SLOTS];
  logic [31:0] tbl_score_tick [SLOTS];
  logic [31:0] tbl_clone_tick [SLOTS];
  logic [7:0]  tbl_clones     [SLOTS];
  logic        tbl_pending    [SLOTS];

  slot_report_t slot_reports[$];
  slot_report_t want;

  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned config_sets = 0;
  int unsigned cycle_count = 0;
  int unsigned zero_gap_left = 0;

  per_process_anomaly_scorer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .slot_i       (slot_i),
    .kind_i       (kind_i),
    .flags_i      (flags_i),
    .is_sandbox_i (is_sandbox_i),
    .now_tick_i   (now_tick_i),
    .done_o       (done_o),
    .pending_o    (pending_o),
    .score_o      (score_o),
    .clone_count_o(clone_count_o),
    .raised_o     (raised_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("per_process_anomaly_scorer_tb NOT OK");
      $finish;
    end
  end

  function automatic void wipe_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_score[i] = '0;
      tbl_score_tick[i] = '0;
      tbl_clone_tick[i] = '0;
      tbl_clones[i] = '0;
      tbl_pending[i] = 1'b0;
    end
  endfunction

  initial wipe_table();

  function automatic logic [15:0] event_weight(input logic [2:0] kind, input logic [1:0] flags);
    case (kind)
      KIND_FAULT:   return cur_threshold;
      KIND_ACCESS: begin
        if (flags[0]) return W_EXEC;
        if (flags[1]) return W_WRITE;
        return W_ACCESS;
      end
      KIND_NETWORK: return W_NETWORK;
      KIND_CRYPTO:  return W_CRYPTO;
      default:      return '0;
    endcase
  endfunction

  // applies one transaction to the mirror and returns the slot report it yields
  function automatic slot_report_t score_table_update(input logic [1:0] cmd,
      input logic [SLOT_W-1:0] slot, input logic [2:0] kind, input logic [1:0] flags,
      input logic sandbox, input logic [31:0] now);
    slot_report_t rep;
    logic [16:0] sum;
    logic [31:0] idle_ticks;
    logic [31:0] since_clone;
    int unsigned s;
    rep = '0;
    s = 32'(slot);
    case (cmd)
      CMD_SCORE: begin
        if ((cur_mode == MODE_TRAP || cur_mode == MODE_QUARANTINE) && !sandbox &&
            kind != KIND_CLONE) begin
          idle_ticks = now - tbl_score_tick[s];
          since_clone = now - tbl_clone_tick[s];
          sum = {1'b0, tbl_score[s]};
          if (sum != '0 && idle_ticks > cur_window) sum = '0;
          sum = sum + {1'b0, event_weight(kind, flags)};
          if (sum > {1'b0, SCORE_MAX}) sum = {1'b0, SCORE_MAX};
          tbl_score[s] = sum[15:0];
          tbl_score_tick[s] = now;
          if (sum[15:0] >= cur_threshold && tbl_clones[s] < cur_budget &&
              !(tbl_clones[s] != '0 && since_clone < cur_cooldown)) begin
            tbl_pending[s] = 1'b1;
            tbl_score[s] = '0;
            rep.raised = 1'b1;
          end
        end
        rep.pending = tbl_pending[s];
      end
      CMD_CLONE: begin
        tbl_clone_tick[s] = now;
        if (tbl_clones[s] != CLONE_MAX) tbl_clones[s]++;
        tbl_pending[s] = 1'b0;
        rep.pending = 1'b0;
      end
      CMD_QUERY: begin
        rep.pending = tbl_pending[s];
        tbl_pending[s] = 1'b0;
      end
      default: rep.pending = tbl_pending[s];
    endcase
    rep.score = tbl_score[s];
    rep.clones = tbl_clones[s];
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (slot_reports.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count++;
      end else begin
        want = slot_reports.pop_front();
        check_field("pending", 32'(want.pending), 32'(pending_o));
        check_field("score", 32'(want.score), 32'(score_o));
        check_field("clone_count", 32'(want.clones), 32'(clone_count_o));
        check_field("raised", 32'(want.raised), 32'(raised_o));
        results_checked++;
      end
    end
  end

  task automatic issue_event(input logic [1:0] cmd, input logic [SLOT_W-1:0] slot,
      input logic [2:0] kind, input logic [1:0] flags, input logic sandbox,
      input logic [31:0] now);
    int unsigned gap;
    if (zero_gap_left > 0) begin
      zero_gap_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= cmd;
    slot_i <= slot;
    kind_i <= kind;
    flags_i <= flags;
    is_sandbox_i <= sandbox;
    now_tick_i <= now;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    slot_reports.push_back(score_table_update(cmd, slot, kind, flags, sandbox, now));
    items_sent++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (slot_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_MODE: begin
        cur_mode = val[1:0];
        wipe_table();
      end
      REG_THRESHOLD: cur_threshold = val[15:0];
      REG_WINDOW:    cur_window = val;
      REG_BUDGET:    cur_budget = val[7:0];
      REG_COOLDOWN:  cur_cooldown = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [1:0] m, input logic [15:0] thr, input logic [31:0] win,
      input logic [7:0] bud, input logic [31:0] cool);
    drain();
    write_reg(REG_MODE, {30'd0, m});
    write_reg(REG_THRESHOLD, {16'd0, thr});
    write_reg(REG_WINDOW, win);
    write_reg(REG_BUDGET, {24'd0, bud});
    write_reg(REG_COOLDOWN, cool);
    config_sets++;
  endtask

  task automatic test_inactive_modes();
    issue_event(CMD_SCORE, 6'd0, KIND_CRYPTO, 2'd0, 1'b0, 32'd0);
    drain();
    write_reg(REG_MODE, {30'd0, MODE_AUDIT});
    issue_event(CMD_SCORE, 6'd0, KIND_CRYPTO, 2'd0, 1'b0, 32'd10);
    issue_event(CMD_CLONE, 6'd1, KIND_FAULT, 2'd0, 1'b0, 32'd20);
  endtask

  task automatic test_event_weights();
    set_config(MODE_TRAP, 16'hFFFF, 32'hFFFF_FFFF, 8'd3, 32'd1000);
    issue_event(CMD_SCORE, 6'd0, KIND_FAULT, 2'd0, 1'b0, 32'h10);
    issue_event(CMD_SCORE, 6'd2, KIND_NETWORK, 2'd0, 1'b0, 32'h10);
    issue_event(CMD_SCORE, 6'd3, KIND_CRYPTO, 2'd0, 1'b0, 32'h10);
    issue_event(CMD_SCORE, 6'd5, KIND_OTHER, 2'd3, 1'b0, 32'h10);
    issue_event(CMD_SCORE, 6'd6, KIND_SPARE_A, 2'd1, 1'b0, 32'h10);
    issue_event(CMD_SCORE, 6'd7, KIND_SPARE_B, 2'd2, 1'b0, 32'h10);
    issue_event(CMD_SCORE, 6'd8, KIND_ACCESS, 2'd0, 1'b0, 32'h10);
    issue_event(CMD_SCORE, 6'd9, KIND_ACCESS, 2'd1, 1'b0, 32'h10);
    issue_event(CMD_SCORE, 6'd10, KIND_ACCESS, 2'd2, 1'b0, 32'h10);
    issue_event(CMD_SCORE, 6'd63, KIND_ACCESS, 2'd3, 1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_raise_and_query();
    set_config(MODE_QUARANTINE, 16'd100, 32'd1000, 8'd3, 32'd1000);
    issue_event(CMD_SCORE, 6'd40, KIND_CRYPTO, 2'd0, 1'b0, 32'd100);
    issue_event(CMD_SCORE, 6'd40, KIND_CRYPTO, 2'd0, 1'b0, 32'd150);
    issue_event(CMD_QUERY, 6'd40, KIND_FAULT, 2'd0, 1'b0, 32'd160);
    issue_event(CMD_QUERY, 6'd40, KIND_FAULT, 2'd0, 1'b0, 32'd170);
    issue_event(CMD_CLONE, 6'd40, KIND_FAULT, 2'd0, 1'b0, 32'd180);
  endtask

  // idle score dropped across the tick wrap, kept at exactly the window
  task automatic test_window_wrap();
    set_config(MODE_TRAP, 16'd100, 32'd100, 8'd3, 32'd1000);
    issue_event(CMD_SCORE, 6'd20, KIND_NETWORK, 2'd0, 1'b0, 32'hFFFF_FFC0);
    issue_event(CMD_SCORE, 6'd20, KIND_NETWORK, 2'd0, 1'b0, 32'h0000_0030);
    issue_event(CMD_SCORE, 6'd20, KIND_NETWORK, 2'd0, 1'b0, 32'h0000_0094);
  endtask

  task automatic test_clone_limits();
    set_config(MODE_TRAP, 16'd10, 32'd100, 8'd2, 32'd50);
    issue_event(CMD_CLONE, 6'd30, KIND_FAULT, 2'd0, 1'b0, 32'd1000);
    issue_event(CMD_SCORE, 6'd30, KIND_NETWORK, 2'd0, 1'b0, 32'd1020);
    issue_event(CMD_SCORE, 6'd30, KIND_NETWORK, 2'd0, 1'b0, 32'd1050);
    issue_event(CMD_CLONE, 6'd30, KIND_FAULT, 2'd0, 1'b0, 32'd1060);
    issue_event(CMD_SCORE, 6'd30, KIND_NETWORK, 2'd0, 1'b0, 32'd1100);
  endtask

  task automatic test_ignored_commands();
    issue_event(CMD_SCORE, 6'd31, KIND_CRYPTO, 2'd0, 1'b1, 32'd2000);
    issue_event(CMD_SCORE, 6'd31, KIND_CLONE, 2'd3, 1'b0, 32'd2010);
    issue_event(CMD_SPARE, 6'd30, KIND_FAULT, 2'd0, 1'b0, 32'd2020);
  endtask

  task automatic test_zero_threshold();
    drain();
    write_reg(REG_THRESHOLD, 32'd0);
    issue_event(CMD_SCORE, 6'd50, KIND_OTHER, 2'd0, 1'b0, 32'd5);
  endtask

  task automatic test_score_saturation();
    drain();
    write_reg(REG_THRESHOLD, 32'h0000_FFFF);
    write_reg(REG_BUDGET, 32'd0);
    issue_event(CMD_SCORE, 6'd62, KIND_FAULT, 2'd0, 1'b0, 32'd0);
    issue_event(CMD_SCORE, 6'd62, KIND_FAULT, 2'd0, 1'b0, 32'd1);
  endtask

  task automatic test_clone_count_saturation();
    logic [31:0] tick;
    tick = $urandom();
    zero_gap_left = 100;
    for (int i = 0; i < 258; i++) begin
      tick = tick + $urandom_range(0, 50);
      issue_event(CMD_CLONE, 6'd0, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), tick);
    end
  endtask

  // few slots, small tick steps and rare jumps so that windows, budgets and cooldowns interact
  task automatic test_random_traffic(input int unsigned n, input int unsigned span);
    logic [31:0] tick;
    logic [1:0] cmd;
    logic [SLOT_W-1:0] base;
    int unsigned pick;
    tick = $urandom();
    base = SLOT_W'($urandom_range(0, SLOTS - 1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) zero_gap_left = $urandom_range(8, 24);
      if ($urandom_range(0, 15) == 0) tick = tick + $urandom();
      else tick = tick + $urandom_range(0, 400);
      pick = $urandom_range(0, 99);
      if (pick < 60) cmd = CMD_SCORE;
      else if (pick < 75) cmd = CMD_CLONE;
      else if (pick < 95) cmd = CMD_QUERY;
      else cmd = CMD_SPARE;
      issue_event(cmd, base + SLOT_W'($urandom_range(0, span - 1)),
                  3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                  $urandom_range(0, 9) == 0, tick);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_inactive_modes();
    test_event_weights();
    test_raise_and_query();
    test_window_wrap();
    test_clone_limits();
    test_ignored_commands();
    test_zero_threshold();
    test_score_saturation();
    test_clone_count_saturation();
    set_config(MODE_TRAP, 16'd100, 32'd1000, 8'd3, 32'd1000);
    test_random_traffic(70, 4);
    set_config(MODE_QUARANTINE, 16'($urandom_range(1, 300)), 32'($urandom_range(20, 500)),
               8'($urandom_range(1, 6)), 32'($urandom_range(0, 300)));
    test_random_traffic(70, 6);
    set_config(MODE_TRAP, 16'd1, 32'd0, 8'hFF, 32'd0);
    test_random_traffic(50, 4);
    set_config(MODE_QUARANTINE, 16'hFFFF, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF);
    test_random_traffic(40, 4);
    set_config(MODE_AUDIT, 16'($urandom_range(1, 200)), $urandom(),
               8'($urandom_range(0, 255)), $urandom());
    test_random_traffic(20, 8);
    set_config(MODE_TRAP, 16'($urandom_range(1, 400)), 32'($urandom_range(50, 2000)),
               8'($urandom_range(1, 8)), 32'($urandom_range(0, 1500)));
    test_random_traffic(60, 3);
    drain();
    $display("sent %0d transactions over %0d register settings, checked %0d results",
             items_sent, config_sets, results_checked);
    $display("covered all modes, weights, window and cooldown wrap, budget and saturation");
    if (fail_count == 0) begin
      $display("per_process_anomaly_scorer_tb OK");
    end else begin
      $display("per_process_anomaly_scorer_tb NOT OK");
    end
    $finish;
  end

endmodule
